// ----- hw/rtl/mips_tlb_translate_and_maintain_macros.svh -----
// Assertion macros for the translation table block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef MIPS_TLB_TRANSLATE_AND_MAINTAIN_MACROS_SVH
`define MIPS_TLB_TRANSLATE_AND_MAINTAIN_MACROS_SVH

// same-cycle implication
`define MTLB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTLB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/mtlb_pkg.sv -----
// Shared types, codes and sizes for the translation table block.
// No dependencies; imported by the controller, datapath and top level.
package mtlb_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 64;
   localparam int SLOT_W = 6;
   localparam int FUNC_W = 3;
   localparam int STATUS_W = 3;
   localparam int WORD_W = 32;
   localparam int VPN_W = 20;
   localparam int PID_W = 6;
   localparam int PFN_W = 20;
   localparam int OFFSET_W = 12;

   localparam logic [FUNC_W-1:0] FUNC_TRANSLATE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PROBE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_INDEXED = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_RANDOM = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNCACHED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_ADDR_LOAD = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ADDR_STORE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_MISS_LOAD = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_MISS_STORE = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_MODIFIED = 3'd6;

   typedef struct packed {
      logic [VPN_W-1:0] vpn;
      logic [PID_W-1:0] pid;
      logic [PFN_W-1:0] pfn;
      logic             n;
      logic             d;
      logic             v;
      logic             g;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic match_en;
      logic pick_en;
      logic read_en;
      logic load_out;
   } cmd_type;

endpackage

// ----- hw/rtl/mtlb_ctrl.sv -----
// Sequencer for the translation table: walks match, pick, read and finish.
// Depends on mtlb_pkg; drives the datapath command struct and rsp_valid.
module mtlb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mtlb_pkg::cmd_type cmd
);
   import mtlb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_PICK,
      ST_READ,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, accept;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      req_stall = reset
                  || !((state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && out_free));
      accept = req_valid && !req_stall;
      cmd.capture = accept;
      cmd.match_en = (state_ff == ST_MATCH);
      cmd.pick_en = (state_ff == ST_PICK);
      cmd.read_en = (state_ff == ST_READ);
      cmd.load_out = (state_ff == ST_FINISH) && out_free;
      rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MATCH;
         end
         ST_MATCH: state_in = ST_PICK;
         ST_PICK: state_in = ST_READ;
         ST_READ: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = accept ? ST_MATCH : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/mtlb_dp.sv -----
// Datapath: item registers, match array, priority pick, entry memory, result register.
// Depends on mtlb_pkg; sequenced by mtlb_ctrl through cmd_type.
module mtlb_dp #(
   parameter int TABLE_ENTRIES = mtlb_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mtlb_pkg::cmd_type               cmd,
   input  logic                            csr_write,
   input  logic                            csr_translation_enable,
   input  logic [mtlb_pkg::FUNC_W-1:0]     req_func,
   input  logic [mtlb_pkg::WORD_W-1:0]     req_virt_addr,
   input  logic [mtlb_pkg::PID_W-1:0]      req_proc_id,
   input  logic                            req_is_load,
   input  logic                            req_user_mode,
   input  logic [mtlb_pkg::WORD_W-1:0]     req_entry_high,
   input  logic [mtlb_pkg::WORD_W-1:0]     req_entry_low,
   input  logic [mtlb_pkg::SLOT_W-1:0]     req_slot,
   input  logic [mtlb_pkg::SLOT_W-1:0]     req_random_slot,
   output logic [mtlb_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mtlb_pkg::WORD_W-1:0]     rsp_phys_addr,
   output logic                            rsp_bad_addr_write,
   output logic [mtlb_pkg::WORD_W-1:0]     rsp_bad_addr,
   output logic                            rsp_probe_miss,
   output logic [mtlb_pkg::SLOT_W-1:0]     rsp_probe_slot,
   output logic [mtlb_pkg::WORD_W-1:0]     rsp_read_high,
   output logic [mtlb_pkg::WORD_W-1:0]     rsp_read_low
);
   import mtlb_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [SLOT_W:0] ENTRIES_LIMIT = (SLOT_W+1)'(TABLE_ENTRIES);

   logic [FUNC_W-1:0] func_ff;
   logic [WORD_W-1:0] va_ff, ehi_ff, elo_ff;
   logic [PID_W-1:0]  pid_ff;
   logic              load_ff, user_ff;
   logic [SLOT_W-1:0] slot_ff, rslot_ff;
   logic              enable_ff;

   logic [VPN_W-1:0]  cam_vpn_ff [TABLE_ENTRIES];
   logic [PID_W-1:0]  cam_pid_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] cam_g_ff, ent_valid_ff;
   entry_type         tbl_mem [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] match_in, match_ff;
   logic              hit_in, hit_ff;
   logic [IDX_W-1:0]  idx_in, idx_ff;
   entry_type         rd_data_ff, rd_ent;
   logic              rd_valid_ff;

   logic [VPN_W-1:0]  key_vpn;
   logic [PID_W-1:0]  key_pid;
   logic [SLOT_W-1:0] wr_slot;
   logic              wr_en, slot_ok;
   logic [IDX_W-1:0]  rd_addr;
   entry_type         wr_ent;

   logic [STATUS_W-1:0] status_in;
   logic [WORD_W-1:0]   phys_in, bad_in, rhigh_in, rlow_in;
   logic                bad_wr_in, pmiss_in;
   logic [SLOT_W-1:0]   pslot_in;

   // capture item and csr
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         va_ff <= req_virt_addr;
         pid_ff <= req_proc_id;
         load_ff <= req_is_load;
         user_ff <= req_user_mode;
         ehi_ff <= req_entry_high;
         elo_ff <= req_entry_low;
         slot_ff <= req_slot;
         rslot_ff <= req_random_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_write) begin
         enable_ff <= csr_translation_enable;
      end
   end

   always_comb begin
      key_vpn = (func_ff == FUNC_PROBE) ? ehi_ff[WORD_W-1:OFFSET_W] : va_ff[WORD_W-1:OFFSET_W];
      key_pid = (func_ff == FUNC_PROBE) ? ehi_ff[OFFSET_W-1:OFFSET_W-PID_W] : pid_ff;
      wr_slot = (func_ff == FUNC_WRITE_RANDOM) ? rslot_ff : slot_ff;
      wr_en = cmd.match_en && ({1'b0, wr_slot} < ENTRIES_LIMIT)
              && ((func_ff == FUNC_WRITE_INDEXED) || (func_ff == FUNC_WRITE_RANDOM));
      wr_ent.vpn = ehi_ff[WORD_W-1:OFFSET_W];
      wr_ent.pid = ehi_ff[OFFSET_W-1:OFFSET_W-PID_W];
      wr_ent.pfn = elo_ff[WORD_W-1:OFFSET_W];
      wr_ent.n = elo_ff[11];
      wr_ent.d = elo_ff[10];
      wr_ent.v = elo_ff[9];
      wr_ent.g = elo_ff[8];
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_in[i] = (cam_vpn_ff[i] == key_vpn) && (cam_g_ff[i] || (cam_pid_ff[i] == key_pid));
      end
   end

   // match keys, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            cam_vpn_ff[i] <= '0;
            cam_pid_ff[i] <= '0;
         end
         cam_g_ff <= '0;
         ent_valid_ff <= '0;
      end else if (wr_en) begin
         cam_vpn_ff[wr_slot[IDX_W-1:0]] <= wr_ent.vpn;
         cam_pid_ff[wr_slot[IDX_W-1:0]] <= wr_ent.pid;
         cam_g_ff[wr_slot[IDX_W-1:0]] <= wr_ent.g;
         ent_valid_ff[wr_slot[IDX_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match_en) match_ff <= match_in;
   end

   // lowest matching slot wins
   always_comb begin
      hit_in = 1'b0;
      idx_in = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (match_ff[i]) begin
            hit_in = 1'b1;
            idx_in = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pick_en) begin
         hit_ff <= hit_in;
         idx_ff <= idx_in;
      end
   end

   assign rd_addr = (func_ff == FUNC_READ) ? slot_ff[IDX_W-1:0] : idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) tbl_mem[wr_slot[IDX_W-1:0]] <= wr_ent;
   end

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_data_ff <= tbl_mem[rd_addr];
         rd_valid_ff <= ent_valid_ff[rd_addr];
      end
   end

   always_comb begin
      rd_ent = rd_valid_ff ? rd_data_ff : entry_type'('0);
      slot_ok = ({1'b0, slot_ff} < ENTRIES_LIMIT);
      status_in = STATUS_OK;
      phys_in = '0;
      bad_wr_in = 1'b0;
      bad_in = '0;
      pmiss_in = 1'b0;
      pslot_in = '0;
      rhigh_in = '0;
      rlow_in = '0;
      unique case (func_ff)
         FUNC_TRANSLATE: begin
            if (!enable_ff) begin
               phys_in = va_ff;
            end else begin
               bad_wr_in = 1'b1;
               bad_in = {va_ff[WORD_W-1:OFFSET_W], OFFSET_W'(0)};
               priority if (user_ff && va_ff[WORD_W-1]) begin
                  status_in = load_ff ? STATUS_ADDR_LOAD : STATUS_ADDR_STORE;
               end else if (!hit_ff || !rd_ent.v) begin
                  status_in = load_ff ? STATUS_MISS_LOAD : STATUS_MISS_STORE;
               end else if (!rd_ent.d && !load_ff) begin
                  status_in = STATUS_MODIFIED;
               end else begin
                  bad_wr_in = 1'b0;
                  bad_in = '0;
                  status_in = rd_ent.n ? STATUS_UNCACHED : STATUS_OK;
                  phys_in = {rd_ent.pfn, va_ff[OFFSET_W-1:0]};
               end
            end
         end
         FUNC_PROBE: begin
            pmiss_in = !hit_ff;
            pslot_in = hit_ff ? SLOT_W'(idx_ff) : '0;
         end
         FUNC_READ: begin
            if (slot_ok) begin
               rhigh_in = {rd_ent.vpn, rd_ent.pid, 6'd0};
               rlow_in = {rd_ent.pfn, rd_ent.n, rd_ent.d, rd_ent.v, rd_ent.g, 8'd0};
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status <= status_in;
         rsp_phys_addr <= phys_in;
         rsp_bad_addr_write <= bad_wr_in;
         rsp_bad_addr <= bad_in;
         rsp_probe_miss <= pmiss_in;
         rsp_probe_slot <= pslot_in;
         rsp_read_high <= rhigh_in;
         rsp_read_low <= rlow_in;
      end
   end

endmodule

// ----- hw/rtl/mips_tlb_translate_and_maintain.sv -----
// Top level of the translation table: controller plus datapath.
// Depends on mtlb_pkg, mtlb_ctrl, mtlb_dp and the assertion macro header.
//
// Usage:
//   req_* carries one operation (translate, probe, read, write indexed,
//   write random); it transfers when req_valid is high and req_stall low.
//   rsp_* returns exactly one result per operation, in order; it transfers
//   when rsp_valid is high and rsp_stall low.
//   csr_* writes translation_enable; csr_ready is always high. Write it
//   only while no operation is in flight.
// Only one operation is in flight: the next is taken once the current one has
//   walked the match, priority pick, entry memory read and result stages.
// A new request is taken in the cycle the previous result is loaded into
//   the output register, once that register is empty or transfers that cycle.
// Stall: while rsp_stall holds a result, an item that reaches the last stage
//   waits there with req_stall high; nothing is lost.
// Reset: synchronous, clears every match key and entry valid bit to zero and disables translation.
module mips_tlb_translate_and_maintain #(
   parameter int TABLE_ENTRIES = mtlb_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mtlb_pkg::FUNC_W-1:0]     req_func,
   input  logic [mtlb_pkg::WORD_W-1:0]     req_virt_addr,
   input  logic [mtlb_pkg::PID_W-1:0]      req_proc_id,
   input  logic                            req_is_load,
   input  logic                            req_user_mode,
   input  logic [mtlb_pkg::WORD_W-1:0]     req_entry_high,
   input  logic [mtlb_pkg::WORD_W-1:0]     req_entry_low,
   input  logic [mtlb_pkg::SLOT_W-1:0]     req_slot,
   input  logic [mtlb_pkg::SLOT_W-1:0]     req_random_slot,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [mtlb_pkg::STATUS_W-1:0]   rsp_status,
   output logic [mtlb_pkg::WORD_W-1:0]     rsp_phys_addr,
   output logic                            rsp_bad_addr_write,
   output logic [mtlb_pkg::WORD_W-1:0]     rsp_bad_addr,
   output logic                            rsp_probe_miss,
   output logic [mtlb_pkg::SLOT_W-1:0]     rsp_probe_slot,
   output logic [mtlb_pkg::WORD_W-1:0]     rsp_read_high,
   output logic [mtlb_pkg::WORD_W-1:0]     rsp_read_low,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_translation_enable
);
   import mtlb_pkg::*;

   `include "mips_tlb_translate_and_maintain_macros.svh"

   cmd_type    cmd;
   logic       csr_write;
   logic [2:0] stage_act;
   logic       bad_addr_shown;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   mtlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mtlb_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .csr_write              (csr_write),
      .csr_translation_enable (csr_translation_enable),
      .req_func               (req_func),
      .req_virt_addr          (req_virt_addr),
      .req_proc_id            (req_proc_id),
      .req_is_load            (req_is_load),
      .req_user_mode          (req_user_mode),
      .req_entry_high         (req_entry_high),
      .req_entry_low          (req_entry_low),
      .req_slot               (req_slot),
      .req_random_slot        (req_random_slot),
      .rsp_status             (rsp_status),
      .rsp_phys_addr          (rsp_phys_addr),
      .rsp_bad_addr_write     (rsp_bad_addr_write),
      .rsp_bad_addr           (rsp_bad_addr),
      .rsp_probe_miss         (rsp_probe_miss),
      .rsp_probe_slot         (rsp_probe_slot),
      .rsp_read_high          (rsp_read_high),
      .rsp_read_low           (rsp_read_low)
   );

   assign stage_act = {cmd.match_en, cmd.pick_en, cmd.read_en};
   assign bad_addr_shown = rsp_valid && rsp_bad_addr_write;

   `MTLB_ASSERT_NEXT(a_accept_starts_match, req_valid && !req_stall, cmd.match_en, "no match")
   `MTLB_ASSERT_NEXT(a_load_shows_valid, cmd.load_out, rsp_valid, "result not presented")
   `MTLB_ASSERT_NOW(a_one_stage_active, 1'b1, $onehot0(stage_act), "stages overlap")
   `MTLB_ASSERT_NOW(a_bad_addr_fault, bad_addr_shown, rsp_status >= STATUS_ADDR_LOAD, "no fault")

endmodule
